FILE: hdl/bsm_pkg.sv
package bsm_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int PIX_W     = 12;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 12;
  localparam int HSUM_W    = 14;
  localparam int SUM_W     = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0]  x;
    logic [HSUM_W-1:0] hs;
    logic [ROW_W-1:0]  row;
    logic              pair_first;
    logic              pair_second;
    logic              last_row;
  } col_op_t;

endpackage

FILE: hdl/bsm_ifs.sv
interface bsm_pixel_if import bsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface bsm_result_if import bsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] smoothed;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_column;
  logic             last_in_run;

  modport source (output valid, output smoothed, output out_row, output out_column,
                  output last_in_run, input ready);
  modport sink   (input valid, input smoothed, input out_row, input out_column,
                  input last_in_run, output ready);
endinterface

FILE: hdl/binomial_3x3_image_smoother.sv
// pipeline: column operations pass s1, s2 (with the line store read) and the output register
// throughput: one pixel per cycle unless stalled, set by the single result output register;
//   the last column of a row needs two line-store updates; on the last row
//   each pixel gives two results (four on the last column), one per cycle while not stalled
// reset: synchronous rst clears the pipeline, counters and prior pixels and sets 640 x 480;
//   the line stores are not cleared and hold nothing valid until written
module binomial_3x3_image_smoother import bsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  bsm_pixel_if.sink             pixels,
  bsm_result_if.source          results
);

  localparam logic [CFG_DATA_W-1:0] MAX_WIDTH_CFG = CFG_DATA_W'(MAX_WIDTH);

  function automatic logic [PIX_W-1:0] round_sum(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = s + SUM_W'(8);
    return t[SUM_W-1:4];
  endfunction

  // line stores
  logic [HSUM_W-1:0] upper  [MAX_WIDTH];
  logic [HSUM_W-1:0] middle [MAX_WIDTH];

  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [PIX_W-1:0] prior_pixel;
  logic [PIX_W-1:0] second_prior_pixel;

  col_op_t s1, pend, s2;
  logic    s1_valid, pend_valid, s2_valid;
  logic [HSUM_W-1:0] up_rd, mid_rd;
  logic [1:0]        phase;
  logic [PIX_W-1:0]  saved_below;
  logic [COL_W-1:0]  saved_col;

  logic              out_valid;
  logic [PIX_W-1:0]  out_smoothed;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_column;
  logic              out_last;

  logic [COL_W-1:0]  col_cl;
  logic [ROW_W-1:0]  row_cl;
  logic              op_a_valid, op_b_valid;
  logic [HSUM_W-1:0] hs_a, hs_b, prior_x, second_x, pix_x;
  col_op_t           op_a, op_b;
  logic              accept, s1_free, s2_take, out_free;

  logic [HSUM_W-1:0] up_sel;
  logic [SUM_W-1:0]  above, below;
  logic [1:0]        n_emit;
  logic              final_emit, emit, done;
  logic [PIX_W-1:0]  sel_smoothed;
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= COL_W'(639);
      h_last <= ROW_W'(479);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_FRAME_WIDTH: begin
          if (cfg_wdata < CFG_DATA_W'(2)) begin
            w_last <= COL_W'(1);
          end else if (cfg_wdata > MAX_WIDTH_CFG) begin
            w_last <= COL_W'(MAX_WIDTH - 1);
          end else begin
            w_last <= COL_W'(cfg_wdata - CFG_DATA_W'(1));
          end
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_wdata < CFG_DATA_W'(2)) begin
            h_last <= ROW_W'(1);
          end else begin
            h_last <= ROW_W'(cfg_wdata - CFG_DATA_W'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // front end: horizontal sums and column operations
  assign out_free = !out_valid || results.ready;
  assign s1_free  = !s1_valid || s2_take;
  assign pixels.ready = !pend_valid && s1_free;
  assign accept   = pixels.valid && pixels.ready;

  always_comb begin
    col_cl   = (col_count > w_last) ? w_last : col_count;
    row_cl   = (row_count > h_last) ? h_last : row_count;
    prior_x  = HSUM_W'(prior_pixel);
    second_x = HSUM_W'(second_prior_pixel);
    pix_x    = HSUM_W'(pixels.pixel_in);
    op_a_valid = col_cl != '0;
    op_b_valid = col_cl == w_last;
    if (col_cl == COL_W'(1)) begin
      hs_a = prior_x + {prior_x[HSUM_W-2:0], 1'b0} + pix_x;
    end else begin
      hs_a = second_x + {prior_x[HSUM_W-2:0], 1'b0} + pix_x;
    end
    hs_b = prior_x + pix_x + {pix_x[HSUM_W-2:0], 1'b0};
    op_a.x           = col_cl - COL_W'(1);
    op_a.hs          = hs_a;
    op_a.row         = row_cl;
    op_a.pair_first  = op_b_valid;
    op_a.pair_second = 1'b0;
    op_a.last_row    = row_cl == h_last;
    op_b.x           = col_cl;
    op_b.hs          = hs_b;
    op_b.row         = row_cl;
    op_b.pair_first  = 1'b0;
    op_b.pair_second = op_a_valid;
    op_b.last_row    = row_cl == h_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count          <= '0;
      row_count          <= '0;
      prior_pixel        <= '0;
      second_prior_pixel <= '0;
    end else if (accept) begin
      second_prior_pixel <= prior_pixel;
      prior_pixel        <= pixels.pixel_in;
      if (col_cl == w_last) begin
        col_count <= '0;
        row_count <= (row_cl == h_last) ? '0 : row_cl + ROW_W'(1);
      end else begin
        col_count <= col_cl + COL_W'(1);
        row_count <= row_cl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pend_valid <= 1'b0;
    end else if (s1_free) begin
      if (pend_valid) begin
        s1         <= pend;
        s1_valid   <= 1'b1;
        pend_valid <= 1'b0;
      end else if (accept && op_a_valid) begin
        s1         <= op_a;
        s1_valid   <= 1'b1;
        pend       <= op_b;
        pend_valid <= op_b_valid;
      end else if (accept && op_b_valid) begin
        s1       <= op_b;
        s1_valid <= 1'b1;
      end else begin
        s1_valid <= 1'b0;
      end
    end
  end

  // line store read, registered
  always_ff @(posedge clk) begin
    if (s2_take) begin
      up_rd  <= upper[s1.x];
      mid_rd <= middle[s1.x];
    end
  end

  // vertical pass and result sequencing
  always_comb begin
    up_sel = (s2.row == ROW_W'(1)) ? mid_rd : up_rd;
    above  = SUM_W'(up_sel) + SUM_W'({mid_rd, 1'b0}) + SUM_W'(s2.hs);
    below  = SUM_W'(mid_rd) + SUM_W'(s2.hs) + SUM_W'({s2.hs, 1'b0});
    if (s2.row == '0) begin
      n_emit = 2'd0;
    end else if (!s2.last_row || s2.pair_first) begin
      n_emit = 2'd1;
    end else if (s2.pair_second) begin
      n_emit = 2'd3;
    end else begin
      n_emit = 2'd2;
    end
    final_emit = phase == (n_emit - 2'd1);
    emit       = s2_valid && (n_emit != 2'd0) && out_free;
    done       = s2_valid && ((n_emit == 2'd0) || (out_free && final_emit));
    s2_take    = !s2_valid || done;
    sel_smoothed = round_sum(below);
    sel_row      = s2.row;
    sel_col      = s2.x;
    case (phase)
      2'd0: begin
        sel_smoothed = round_sum(above);
        sel_row      = s2.row - ROW_W'(1);
      end
      2'd1: begin
        if (s2.pair_second) begin
          sel_smoothed = saved_below;
          sel_col      = saved_col;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      phase    <= '0;
    end else if (s2_take) begin
      s2_valid <= s1_valid;
      s2       <= s1;
      phase    <= '0;
    end else if (emit) begin
      phase <= phase + 2'd1;
    end
  end

  // write back
  always_ff @(posedge clk) begin
    if (done) begin
      middle[s2.x] <= s2.hs;
      if (s2.row != '0) begin
        upper[s2.x] <= mid_rd;
      end
    end
  end

  // bottom-row result of the first column of a pair waits for the second column
  always_ff @(posedge clk) begin
    if (done && s2.pair_first && s2.last_row) begin
      saved_below <= round_sum(below);
      saved_col   <= s2.x;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      out_smoothed <= sel_smoothed;
      out_row      <= sel_row;
      out_column   <= sel_col;
      out_last     <= final_emit && !s2.pair_first;
    end
  end

  assign results.valid       = out_valid;
  assign results.smoothed    = out_smoothed;
  assign results.out_row     = out_row;
  assign results.out_column  = out_column;
  assign results.last_in_run = out_last;

endmodule

FILE: hdl/bsm_checker.sv
module bsm_checker import bsm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] smoothed,
  input logic [ROW_W-1:0] out_row,
  input logic [COL_W-1:0] out_column,
  input logic             last_in_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(smoothed) && $stable(out_row)
      && $stable(out_column) && $stable(last_in_run))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("pixel withdrawn before transaction");

endmodule

bind binomial_3x3_image_smoother bsm_checker u_bsm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pixels.valid),
  .in_ready    (pixels.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .smoothed    (results.smoothed),
  .out_row     (results.out_row),
  .out_column  (results.out_column),
  .last_in_run (results.last_in_run)
);
